@@ rtl/audio_to_haptics_dsp_defines.svh @@
// ---------------------------------------------------------------------------
// audio_to_haptics_dsp_defines.svh
// Assertion macros for the audio-to-haptics RTL, used by a2h_ctrl.
// ---------------------------------------------------------------------------
`ifndef AUDIO_TO_HAPTICS_DSP_DEFINES_SVH
`define AUDIO_TO_HAPTICS_DSP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property on every rising clock edge outside reset.
`define A2H_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("a2h assertion failed");
// Check that a condition never holds.
`define A2H_NEVER(lbl, expr) \
  `A2H_ASSERT(lbl, !(expr))
`else
`define A2H_ASSERT(lbl, prop)
`define A2H_NEVER(lbl, expr)
`endif

`endif

@@ rtl/a2h_pkg.sv @@
// ---------------------------------------------------------------------------
// a2h_pkg
// Types, register map and constants for the audio-to-haptics block.
// ---------------------------------------------------------------------------
`default_nettype none

package a2h_pkg;

  localparam int DECIMATION_DEF = 16;

  localparam int ONE_Q22     = 4194304;
  localparam int ENV_ATTACK  = 26214;  // 0.40 in Q0.16
  localparam int ENV_RELEASE = 1638;   // 0.025 in Q0.16
  localparam int DIV_STEPS   = 22;     // soft-clip quotient bits

  localparam int MUL_A_W = 28;
  localparam int MUL_B_W = 26;
  localparam int PROD_W  = 55;

  localparam logic [1:0] REG_HAPTIC_MODE   = 2'd0;
  localparam logic [1:0] REG_LOWPASS_COEFF = 2'd1;
  localparam logic [1:0] REG_NATIVE_GAIN   = 2'd2;
  localparam logic [1:0] REG_DERIVED_GAIN  = 2'd3;

  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_REPLACE = 2'd2;

  localparam logic [15:0] LOWPASS_COEFF_RST = 16'd1700;
  localparam logic [15:0] GAIN_RST          = 16'd4096;

  typedef struct packed {
    logic [1:0]  haptic_mode;
    logic [15:0] lowpass_coeff;
    logic [15:0] native_gain;
    logic [15:0] derived_gain;
  } a2h_cfg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_NAT_MUL,
    OP_NAT_RND,
    OP_SLP_MUL,
    OP_SLP_UPD,
    OP_ENV_MUL,
    OP_ENV_UPD,
    OP_MOD_MUL,
    OP_MOD_RND,
    OP_GAIN_MUL,
    OP_GAIN_RND,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_CLIP_A,
    OP_CLIP_H,
    OP_NLP_MUL,
    OP_NLP_UPD,
    OP_SUM,
    OP_STORE
  } a2h_op_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_NAT_MUL,
    ST_NAT_RND,
    ST_SLP_MUL,
    ST_SLP_UPD,
    ST_ENV_MUL,
    ST_ENV_UPD,
    ST_MOD_MUL,
    ST_MOD_RND,
    ST_GAIN_MUL,
    ST_GAIN_RND,
    ST_DIV1_LOAD,
    ST_DIV1,
    ST_CLIP1,
    ST_NLP_MUL,
    ST_NLP_UPD,
    ST_SUM,
    ST_DIV2_LOAD,
    ST_DIV2,
    ST_CLIP2,
    ST_STORE,
    ST_FINISH
  } a2h_state_e;

  typedef struct packed {
    a2h_op_e op;
    logic    ch;
    logic    load_in;
    logic    load_out;
  } a2h_cmd_t;

  typedef struct packed {
    logic dsp;
    logic replace;
    logic div_last;
  } a2h_sts_t;

endpackage

`default_nettype wire

@@ rtl/a2h_datapath.sv @@
// ---------------------------------------------------------------------------
// a2h_datapath
// Channel state, shared multiplier, soft-clip divider and drive registers.
// ---------------------------------------------------------------------------
`default_nettype none

module a2h_datapath (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire a2h_pkg::a2h_cfg_t   cfg_i,
  input  wire a2h_pkg::a2h_cmd_t   cmd_i,
  output a2h_pkg::a2h_sts_t        sts_o,
  input  wire logic signed [15:0]  speaker_left_i,
  input  wire logic signed [15:0]  speaker_right_i,
  input  wire logic signed [15:0]  native_left_i,
  input  wire logic signed [15:0]  native_right_i,
  input  wire logic                four_channel_i,
  output logic signed [7:0]        drive_left_o,
  output logic signed [7:0]        drive_right_o
);
  import a2h_pkg::*;

  function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
    if (v > 32'sd8388607) begin
      return 24'sh7FFFFF;
    end else if (v < -32'sd8388608) begin
      return 24'sh800000;
    end
    return v[23:0];
  endfunction

  function automatic logic signed [31:0] rnd16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + PROD_W'(32768);
    return 32'(t >>> 16);
  endfunction

  logic signed [15:0] spk_q [2];
  logic signed [15:0] nat_q [2];
  logic               four_q;
  logic signed [23:0] slp_q [2];
  logic signed [23:0] nlp_q [2];
  logic signed [23:0] env_q [2];
  logic signed [7:0]  drv_q [2];
  logic signed [7:0]  out_l_q, out_r_q;

  logic signed [PROD_W-1:0] prod_q, prod_d;
  logic signed [27:0]       h_q;
  logic signed [31:0]       v_q;
  logic signed [22:0]       a_q;

  logic [34:0] r_q;
  logic [32:0] den_q;
  logic [21:0] q_q;
  logic        neg_q;
  logic [4:0]  cnt_q;

  logic                     ch;
  logic signed [15:0]       cur_spk, cur_nat;
  logic signed [23:0]       cur_slp, cur_nlp, cur_env;
  logic signed [22:0]       spk_x;
  logic signed [24:0]       slp_diff, nlp_diff, env_diff, slp_mag, mag;
  logic signed [23:0]       h_sat;
  logic                     attack;
  logic [25:0]              mod;
  logic signed [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0]       mul_b;
  logic signed [PROD_W-1:0] rnd_t;
  logic [31:0]              xm;
  logic [34:0]              r2;
  logic signed [22:0]       q_signed;
  logic [27:0]              h_mag;
  logic [22:0]              h_clamp;
  logic [29:0]              h_127;
  logic [7:0]               drv_mag;
  logic signed [7:0]        drv_val;

  assign ch      = cmd_i.ch;
  assign cur_spk = spk_q[ch];
  assign cur_nat = nat_q[ch];
  assign cur_slp = slp_q[ch];
  assign cur_nlp = nlp_q[ch];
  assign cur_env = env_q[ch];

  assign sts_o.dsp      = (cfg_i.haptic_mode != MODE_OFF) || !four_q;
  assign sts_o.replace  = (cfg_i.haptic_mode == MODE_REPLACE) || !four_q;
  assign sts_o.div_last = (cnt_q == 5'd1);

  always_comb begin
    spk_x    = {cur_spk, 7'b0};
    slp_diff = 25'(spk_x) - 25'(cur_slp);
    h_sat    = sat24(32'(h_q));
    nlp_diff = 25'(h_sat) - 25'(cur_nlp);
    slp_mag  = (cur_slp < 0) ? -25'(cur_slp) : 25'(cur_slp);
    mag      = (slp_mag > 25'sd8388607) ? 25'sd8388607 : slp_mag;
    env_diff = mag - 25'(cur_env);
    attack   = mag > 25'(cur_env);
    mod      = 26'(ONE_Q22) + 26'(cur_env[22:0]) + {2'b0, cur_env[22:0], 1'b0};
  end

  // Operand select for the one shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd_i.op)
      OP_NAT_MUL: begin
        mul_a = MUL_A_W'(cur_nat);
        mul_b = MUL_B_W'(cfg_i.native_gain);
      end
      OP_SLP_MUL: begin
        mul_a = MUL_A_W'(slp_diff);
        mul_b = MUL_B_W'(cfg_i.lowpass_coeff);
      end
      OP_ENV_MUL: begin
        mul_a = MUL_A_W'(env_diff);
        mul_b = attack ? MUL_B_W'(ENV_ATTACK) : MUL_B_W'(ENV_RELEASE);
      end
      OP_MOD_MUL: begin
        mul_a = MUL_A_W'(cur_slp);
        mul_b = mod;
      end
      OP_GAIN_MUL: begin
        mul_a = v_q[MUL_A_W-1:0];
        mul_b = MUL_B_W'(cfg_i.derived_gain);
      end
      OP_NLP_MUL: begin
        mul_a = MUL_A_W'(nlp_diff);
        mul_b = MUL_B_W'(cfg_i.lowpass_coeff);
      end
      default: begin
      end
    endcase
  end

  assign prod_d = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

  always_comb begin
    xm       = v_q[31] ? (32'(~v_q) + 32'd1) : 32'(v_q);
    r2       = {r_q[33:0], 1'b0};
    q_signed = neg_q ? -$signed({1'b0, q_q}) : $signed({1'b0, q_q});
    rnd_t    = prod_q + PROD_W'(2097152);
    h_mag    = h_q[27] ? (~h_q + 28'd1) : h_q;
    h_clamp  = (h_mag > 28'(ONE_Q22)) ? 23'(ONE_Q22) : h_mag[22:0];
    h_127    = {h_clamp, 7'b0} - 30'(h_clamp);
    drv_mag  = {1'b0, h_127[28:22]};
    drv_val  = h_q[27] ? -$signed(drv_mag) : $signed(drv_mag);
  end

  // Filter and envelope state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        slp_q[i] <= '0;
        nlp_q[i] <= '0;
        env_q[i] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_SLP_UPD: slp_q[ch] <= sat24(32'(cur_slp) + rnd16(prod_q));
        OP_ENV_UPD: env_q[ch] <= sat24(32'(cur_env) + rnd16(prod_q));
        OP_NLP_UPD: nlp_q[ch] <= sat24(32'(cur_nlp) + rnd16(prod_q));
        default: begin
        end
      endcase
    end
  end

  // Working registers and divider.
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (cmd_i.load_in) begin
      spk_q[0] <= speaker_left_i;
      spk_q[1] <= speaker_right_i;
      nat_q[0] <= native_left_i;
      nat_q[1] <= native_right_i;
      four_q   <= four_channel_i;
    end
    if (cmd_i.load_out) begin
      out_l_q <= drv_q[0];
      out_r_q <= drv_q[1];
    end
    case (cmd_i.op)
      OP_NAT_RND: begin
        h_q <= four_q ? 28'((prod_q + PROD_W'(16)) >>> 5) : '0;
      end
      OP_MOD_RND:  v_q <= 32'(rnd_t >>> 22);
      OP_GAIN_RND: v_q <= 32'((prod_q + PROD_W'(2048)) >>> 12);
      OP_DIV_LOAD: begin
        neg_q <= v_q[31];
        r_q   <= 35'(xm);
        den_q <= 33'(ONE_Q22) + 33'(xm);
        q_q   <= '0;
        cnt_q <= 5'(DIV_STEPS);
      end
      OP_DIV_STEP: begin
        if (r2 >= 35'(den_q)) begin
          r_q <= r2 - 35'(den_q);
          q_q <= {q_q[20:0], 1'b1};
        end else begin
          r_q <= r2;
          q_q <= {q_q[20:0], 1'b0};
        end
        cnt_q <= cnt_q - 5'd1;
      end
      OP_CLIP_A: a_q <= q_signed;
      OP_CLIP_H: h_q <= 28'(q_signed);
      OP_SUM:    v_q <= 32'(cur_nlp) + 32'(a_q);
      OP_STORE:  drv_q[ch] <= drv_val;
      default: begin
      end
    endcase
  end

  assign drive_left_o  = out_l_q;
  assign drive_right_o = out_r_q;

endmodule

`default_nettype wire

@@ rtl/a2h_ctrl.sv @@
// ---------------------------------------------------------------------------
// a2h_ctrl
// Sequencer for one frame: per-channel steps, decimation and output hold.
// ---------------------------------------------------------------------------
`default_nettype none

`include "audio_to_haptics_dsp_defines.svh"

module a2h_ctrl #(
  parameter int DECIMATION = a2h_pkg::DECIMATION_DEF
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  input  wire a2h_pkg::a2h_sts_t sts_i,
  output a2h_pkg::a2h_cmd_t      cmd_o
);
  import a2h_pkg::*;

  localparam int PH_W = (DECIMATION > 1) ? $clog2(DECIMATION) : 1;

  a2h_state_e      st_q, st_d;
  logic            ch_q, ch_d;
  logic [PH_W-1:0] phase_q, phase_d;
  logic            out_valid_q, out_valid_d;
  logic            emit;

  assign emit        = (phase_q == PH_W'(DECIMATION - 1));
  assign in_stall_o  = (st_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ch_q        <= 1'b0;
      phase_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      ch_q        <= ch_d;
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    st_d           = st_q;
    ch_d           = ch_q;
    phase_d        = phase_q;
    out_valid_d    = out_valid_q && out_stall_i;
    cmd_o.op       = OP_NONE;
    cmd_o.ch       = ch_q;
    cmd_o.load_in  = 1'b0;
    cmd_o.load_out = 1'b0;
    unique case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          ch_d          = 1'b0;
          st_d          = ST_NAT_MUL;
        end
      end
      ST_NAT_MUL: begin
        cmd_o.op = OP_NAT_MUL;
        st_d     = ST_NAT_RND;
      end
      ST_NAT_RND: begin
        cmd_o.op = OP_NAT_RND;
        st_d     = sts_i.dsp ? ST_SLP_MUL : ST_STORE;
      end
      ST_SLP_MUL: begin
        cmd_o.op = OP_SLP_MUL;
        st_d     = ST_SLP_UPD;
      end
      ST_SLP_UPD: begin
        cmd_o.op = OP_SLP_UPD;
        st_d     = ST_ENV_MUL;
      end
      ST_ENV_MUL: begin
        cmd_o.op = OP_ENV_MUL;
        st_d     = ST_ENV_UPD;
      end
      ST_ENV_UPD: begin
        cmd_o.op = OP_ENV_UPD;
        st_d     = ST_MOD_MUL;
      end
      ST_MOD_MUL: begin
        cmd_o.op = OP_MOD_MUL;
        st_d     = ST_MOD_RND;
      end
      ST_MOD_RND: begin
        cmd_o.op = OP_MOD_RND;
        st_d     = ST_GAIN_MUL;
      end
      ST_GAIN_MUL: begin
        cmd_o.op = OP_GAIN_MUL;
        st_d     = ST_GAIN_RND;
      end
      ST_GAIN_RND: begin
        cmd_o.op = OP_GAIN_RND;
        st_d     = ST_DIV1_LOAD;
      end
      ST_DIV1_LOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        st_d     = ST_DIV1;
      end
      ST_DIV1: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) begin
          st_d = ST_CLIP1;
        end
      end
      ST_CLIP1: begin
        cmd_o.op = sts_i.replace ? OP_CLIP_H : OP_CLIP_A;
        st_d     = sts_i.replace ? ST_STORE : ST_NLP_MUL;
      end
      ST_NLP_MUL: begin
        cmd_o.op = OP_NLP_MUL;
        st_d     = ST_NLP_UPD;
      end
      ST_NLP_UPD: begin
        cmd_o.op = OP_NLP_UPD;
        st_d     = ST_SUM;
      end
      ST_SUM: begin
        cmd_o.op = OP_SUM;
        st_d     = ST_DIV2_LOAD;
      end
      ST_DIV2_LOAD: begin
        cmd_o.op = OP_DIV_LOAD;
        st_d     = ST_DIV2;
      end
      ST_DIV2: begin
        cmd_o.op = OP_DIV_STEP;
        if (sts_i.div_last) begin
          st_d = ST_CLIP2;
        end
      end
      ST_CLIP2: begin
        cmd_o.op = OP_CLIP_H;
        st_d     = ST_STORE;
      end
      ST_STORE: begin
        cmd_o.op = OP_STORE;
        if (!ch_q) begin
          ch_d = 1'b1;
          st_d = ST_NAT_MUL;
        end else begin
          st_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!emit) begin
          phase_d = phase_q + PH_W'(1);
          st_d    = ST_IDLE;
        end else if (!(out_valid_q && out_stall_i)) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          phase_d        = '0;
          st_d           = ST_IDLE;
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  `A2H_ASSERT(a_accept_busy, (in_valid_i && !in_stall_o) |=> (st_q == ST_NAT_MUL))
  `A2H_ASSERT(a_phase_range, 32'(phase_q) < DECIMATION)
  `A2H_ASSERT(a_result_on_wrap, $rose(out_valid_q) |-> (phase_q == '0))
  `A2H_NEVER(a_load_over_pending, cmd_o.load_out && out_valid_q && out_stall_i)

endmodule

`default_nettype wire

@@ rtl/audio_to_haptics_dsp.sv @@
// ---------------------------------------------------------------------------
// audio_to_haptics_dsp
// Audio frames in, decimated int8 haptic drive pairs out, APB register set.
// ---------------------------------------------------------------------------
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------
//   in      | request   | in_valid_i / in_stall_o | speaker, native, four_channel
//   out     | result    | out_valid_o/out_stall_i | drive_left, drive_right
//   cfg     | APB write | psel/penable/pwrite     | paddr, pwdata, prdata
//
// A new frame is accepted only once the last one has finished its steps, so
// frame spacing is set by the soft-clip divisions (one per channel in replace
// mode, two in mix, on the shared restoring divider) and the single shared
// multiplier, and is shortest with auto-haptics off.
// Reset clears the filter and envelope state and the decimation phase.
// A finished drive pair sits in the output register while the next frame runs;
// a frame that must emit while that pair is still stalled holds in its last step.
//
`default_nettype none

module audio_to_haptics_dsp #(
  parameter int DECIMATION = a2h_pkg::DECIMATION_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // Frame input
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic signed [15:0] speaker_left_i,
  input  wire logic signed [15:0] speaker_right_i,
  input  wire logic signed [15:0] native_left_i,
  input  wire logic signed [15:0] native_right_i,
  input  wire logic               four_channel_i,
  // Drive output
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [7:0]       drive_left_o,
  output logic signed [7:0]       drive_right_o,
  // Register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [3:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import a2h_pkg::*;

  a2h_cfg_t cfg_q;
  a2h_cmd_t cmd;
  a2h_sts_t sts;
  logic     wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes land on the access phase; unused bits drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.haptic_mode   <= MODE_OFF;
      cfg_q.lowpass_coeff <= LOWPASS_COEFF_RST;
      cfg_q.native_gain   <= GAIN_RST;
      cfg_q.derived_gain  <= GAIN_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_HAPTIC_MODE:   cfg_q.haptic_mode   <= pwdata[1:0];
        REG_LOWPASS_COEFF: cfg_q.lowpass_coeff <= pwdata[15:0];
        REG_NATIVE_GAIN:   cfg_q.native_gain   <= pwdata[15:0];
        REG_DERIVED_GAIN:  cfg_q.derived_gain  <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Read back the addressed register.
  always_comb begin
    unique case (paddr[3:2])
      REG_HAPTIC_MODE:   prdata = 32'(cfg_q.haptic_mode);
      REG_LOWPASS_COEFF: prdata = 32'(cfg_q.lowpass_coeff);
      REG_NATIVE_GAIN:   prdata = 32'(cfg_q.native_gain);
      REG_DERIVED_GAIN:  prdata = 32'(cfg_q.derived_gain);
      default:           prdata = '0;
    endcase
  end

  // Sequencer: walks each channel through filter, envelope, gain and clip when the DSP path is on.
  a2h_ctrl #(
    .DECIMATION (DECIMATION)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Arithmetic: shared multiplier, divider and per-channel state.
  a2h_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .speaker_left_i  (speaker_left_i),
    .speaker_right_i (speaker_right_i),
    .native_left_i   (native_left_i),
    .native_right_i  (native_right_i),
    .four_channel_i  (four_channel_i),
    .drive_left_o    (drive_left_o),
    .drive_right_o   (drive_right_o)
  );

endmodule

`default_nettype wire
